// ----- rtl/henon_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// henon_pkg
// Types and constants shared by the complex Henon escape-time block and its
// checker.
// ----------------------------------------------------------------------------
package henon_pkg;

    localparam int VAL_W       = 32;
    localparam int ITER_BITS   = 10;
    localparam int CODE_W      = ITER_BITS + 2;
    localparam int CFG_INDEX_W = 3;
    localparam int ESCAPE_NORM = 100;
    localparam int LIMIT_RESET = 50;

    localparam logic [1:0] OUTCOME_FORWARD  = 2'd0;
    localparam logic [1:0] OUTCOME_BACKWARD = 2'd1;
    localparam logic [1:0] OUTCOME_BOUNDED  = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_X_RE    = 3'd0,
        REG_START_X_IM    = 3'd1,
        REG_START_Y_RE    = 3'd2,
        REG_START_Y_IM    = 3'd3,
        REG_ITERATION_LIM = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] point_re;
        logic signed [VAL_W-1:0] point_im;
    } point_t;

    typedef struct packed {
        logic [1:0]               outcome;
        logic [ITER_BITS-1:0]     steps;
        logic signed [CODE_W-1:0] colour_code;
    } result_t;

endpackage

// ----- rtl/henon_escape_time.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// henon_escape_time
// Escape-time colour code for the complex Henon family, Q8.24 fixed point,
// computed on one shared 32x32 signed multiplier.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Each map step forms three products on the
// single registered 32x32 multiplier (re*re, im*im, re*im) in states SQ_RR,
// SQ_II and SQ_RI, then makes the escape decision and the saturating update
// in the CHECK state. If the forward run does not escape before the
// iteration limit, a backward run follows, with one more pass for the escape
// test of the starting x. The iteration limit resets to 50. The point input
// is stalled while an item is at work; a finished result may sit in the
// output register while the next item is accepted. Configuration must be
// written only while idle; the block itself does not enforce this.
module henon_escape_time #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_stall,
    input  henon_pkg::point_t                   point,
    output logic                                result_valid,
    input  logic                                result_stall,
    output henon_pkg::result_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [henon_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [henon_pkg::VAL_W-1:0]         cfg_data
);
    import henon_pkg::*;

    localparam int PW = 2 * VAL_W;
    localparam int SW = PW + 3;
    localparam int CW = (2 * FRAC_BITS + 8 > PW + 2) ? 2 * FRAC_BITS + 8 : PW + 2;
    localparam logic [CW-1:0] ESC_THR = CW'(ESCAPE_NORM) << (2 * FRAC_BITS);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SQ_RR = 6'b000010,
        ST_SQ_II = 6'b000100,
        ST_SQ_RI = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [VAL_W-1:0] start_x_re_reg, start_x_im_reg;
    logic signed [VAL_W-1:0] start_y_re_reg, start_y_im_reg;
    logic [ITER_BITS-1:0]    limit_reg;

    logic signed [VAL_W-1:0] x_re_reg, x_im_reg, y_re_reg, y_im_reg;
    logic signed [VAL_W-1:0] x_re_next, x_im_next, y_re_next, y_im_next;
    logic signed [VAL_W-1:0] t_re_reg, t_im_reg;
    logic [ITER_BITS-1:0]    iter_reg, iter_next;
    logic                    back_reg, back_next;
    logic                    first_reg, first_next;

    logic signed [PW-1:0]    prod_reg, prod_next;
    logic signed [PW-1:0]    rr_reg;
    logic signed [PW:0]      diff_reg;
    logic                    esc_reg;

    result_t res_reg, res_next;
    result_t result_reg;
    logic    result_valid_reg;

    logic signed [VAL_W-1:0] op_re, op_im, mul_a, mul_b;
    logic [PW:0]             norm_sum;
    logic                    esc_next;
    logic signed [PW:0]      sq_re;
    logic signed [PW-1:0]    sq_im;
    logic signed [SW-1:0]    fwd_re, fwd_im, bwd_re, bwd_im;
    logic [ITER_BITS-1:0]    iter_inc;
    logic                    out_free;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SW-1:0] v);
        logic signed [VAL_W-1:0] r;
        if ((&v[SW-1:VAL_W-1]) || !(|v[SW-1:VAL_W-1]))
        begin
            r = v[VAL_W-1:0];
        end
        else if (v[SW-1])
        begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic result_t make_result(input logic [1:0] oc,
                                            input logic [ITER_BITS-1:0] n);
        result_t r;
        r.outcome = oc;
        unique case (oc)
            OUTCOME_FORWARD:
            begin
                r.steps       = n;
                r.colour_code = {1'b0, n, 1'b0};
            end
            OUTCOME_BACKWARD:
            begin
                r.steps       = n;
                r.colour_code = {1'b0, n, 1'b1};
            end
            default:
            begin
                r.steps       = '0;
                r.colour_code = '1;
            end
        endcase
        return r;
    endfunction

    assign cfg_ready    = 1'b1;
    assign point_stall  = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_re_reg <= '0;
            start_x_im_reg <= '0;
            start_y_re_reg <= '0;
            start_y_im_reg <= '0;
            limit_reg      <= ITER_BITS'(LIMIT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_X_RE:    start_x_re_reg <= cfg_data;
                REG_START_X_IM:    start_x_im_reg <= cfg_data;
                REG_START_Y_RE:    start_y_re_reg <= cfg_data;
                REG_START_Y_IM:    start_y_im_reg <= cfg_data;
                REG_ITERATION_LIM: limit_reg      <= cfg_data[ITER_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // shared multiplier operands
    assign op_re = (back_reg && !first_reg) ? y_re_reg : x_re_reg;
    assign op_im = (back_reg && !first_reg) ? y_im_reg : x_im_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_SQ_RR:
            begin
                mul_a = op_re;
                mul_b = op_re;
            end
            ST_SQ_II:
            begin
                mul_a = op_im;
                mul_b = op_im;
            end
            default:
            begin
                mul_a = op_re;
                mul_b = op_im;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // norm of the operand, valid in the re*im cycle
    assign norm_sum = {1'b0, rr_reg} + {1'b0, prod_reg};
    assign esc_next = (CW'(norm_sum) >= ESC_THR);

    // square and the two map updates
    assign sq_re  = diff_reg >>> FRAC_BITS;
    assign sq_im  = prod_reg >>> (FRAC_BITS - 1);
    assign fwd_re = SW'(y_re_reg) + SW'(sq_re) + SW'(t_re_reg);
    assign fwd_im = SW'(y_im_reg) + SW'(sq_im) + SW'(t_im_reg);
    assign bwd_re = SW'(x_re_reg) - SW'(sq_re) - SW'(t_re_reg);
    assign bwd_im = SW'(x_im_reg) - SW'(sq_im) - SW'(t_im_reg);
    assign iter_inc = iter_reg + 1'b1;
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        x_re_next  = x_re_reg;
        x_im_next  = x_im_reg;
        y_re_next  = y_re_reg;
        y_im_next  = y_im_reg;
        iter_next  = iter_reg;
        back_next  = back_reg;
        first_next = first_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (point_valid)
                begin
                    x_re_next  = start_x_re_reg;
                    x_im_next  = start_x_im_reg;
                    y_re_next  = start_y_re_reg;
                    y_im_next  = start_y_im_reg;
                    iter_next  = '0;
                    back_next  = 1'b0;
                    first_next = 1'b0;
                    state_next = ST_SQ_RR;
                end
            end
            ST_SQ_RR:
            begin
                state_next = ST_SQ_II;
            end
            ST_SQ_II:
            begin
                state_next = ST_SQ_RI;
            end
            ST_SQ_RI:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!back_reg)
                begin
                    priority if (iter_reg == limit_reg)
                    begin
                        // bounded forward, restart backward from the start pair
                        x_re_next  = start_x_re_reg;
                        x_im_next  = start_x_im_reg;
                        y_re_next  = start_y_re_reg;
                        y_im_next  = start_y_im_reg;
                        iter_next  = '0;
                        back_next  = 1'b1;
                        first_next = 1'b1;
                        state_next = ST_SQ_RR;
                    end
                    else if (esc_reg)
                    begin
                        res_next   = make_result(OUTCOME_FORWARD, iter_reg);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        x_re_next  = sat_val(fwd_re);
                        x_im_next  = sat_val(fwd_im);
                        y_re_next  = x_re_reg;
                        y_im_next  = x_im_reg;
                        iter_next  = iter_inc;
                        state_next = ST_SQ_RR;
                    end
                end
                else if (first_reg)
                begin
                    // escape test on the starting x only
                    priority if (iter_reg == limit_reg)
                    begin
                        res_next   = make_result(OUTCOME_BOUNDED, iter_reg);
                        state_next = ST_EMIT;
                    end
                    else if (esc_reg)
                    begin
                        res_next   = make_result(OUTCOME_BACKWARD, iter_reg);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        first_next = 1'b0;
                        state_next = ST_SQ_RR;
                    end
                end
                else
                begin
                    // norm of y is the norm of the new x
                    x_re_next = y_re_reg;
                    x_im_next = y_im_reg;
                    y_re_next = sat_val(bwd_re);
                    y_im_next = sat_val(bwd_im);
                    iter_next = iter_inc;
                    priority if (iter_inc == limit_reg)
                    begin
                        res_next   = make_result(OUTCOME_BOUNDED, iter_inc);
                        state_next = ST_EMIT;
                    end
                    else if (esc_reg)
                    begin
                        res_next   = make_result(OUTCOME_BACKWARD, iter_inc);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SQ_RR;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            back_reg         <= 1'b0;
            first_reg        <= 1'b0;
            iter_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            back_reg  <= back_next;
            first_reg <= first_next;
            iter_reg  <= iter_next;
            if (state_reg == ST_EMIT && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_re_reg <= x_re_next;
        x_im_reg <= x_im_next;
        y_re_reg <= y_re_next;
        y_im_reg <= y_im_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        if (state_reg == ST_IDLE && point_valid)
        begin
            t_re_reg <= point.point_re;
            t_im_reg <= point.point_im;
        end
        if (state_reg == ST_SQ_II)
        begin
            rr_reg <= prod_reg;
        end
        if (state_reg == ST_SQ_RI)
        begin
            diff_reg <= {rr_reg[PW-1], rr_reg} - {prod_reg[PW-1], prod_reg};
            esc_reg  <= esc_next;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            result_reg <= res_reg;
        end
    end

endmodule

// ----- rtl/henon_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// henon_chk
// Port-level checks for the Henon escape-time block, bound to its top level.
// ----------------------------------------------------------------------------
module henon_chk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    input  logic               point_stall,
    input  logic               result_valid,
    input  logic               result_stall,
    input  henon_pkg::result_t result
);
    import henon_pkg::*;

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result item changed under stall");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |=> point_stall)
        else $error("point taken while an item is at work");

    // outcome code in range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.outcome == OUTCOME_FORWARD ||
                          result.outcome == OUTCOME_BACKWARD ||
                          result.outcome == OUTCOME_BOUNDED))
        else $error("bad outcome code");

    // bounded items carry no steps and the all-ones code
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.outcome == OUTCOME_BOUNDED
            |-> result.steps == '0 && result.colour_code == '1)
        else $error("bounded item with steps or code set");

    // escaping items: code is twice the steps, odd for backward
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.outcome != OUTCOME_BOUNDED
            |-> result.colour_code[CODE_W-1] == 1'b0 &&
                result.colour_code[ITER_BITS:1] == result.steps &&
                result.colour_code[0] == result.outcome[0])
        else $error("colour code does not match steps");

endmodule

bind henon_escape_time henon_chk u_henon_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
